### rtl/cis_pkg.sv
package cis_pkg;

   // Stack geometry and length field widths
   localparam int MAX_DEPTH = 16;
   localparam int IDX_W     = $clog2(MAX_DEPTH);
   localparam int LVL_W     = IDX_W + 1;
   localparam int LEN_BITS  = 16;
   localparam int CNT_W     = LEN_BITS + 1;
   localparam int LIMIT_W   = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_DEPTH);

   // Major types of a head byte
   localparam logic [2:0] MAJ_UINT   = 3'd0;
   localparam logic [2:0] MAJ_NINT   = 3'd1;
   localparam logic [2:0] MAJ_BYTES  = 3'd2;
   localparam logic [2:0] MAJ_TEXT   = 3'd3;
   localparam logic [2:0] MAJ_ARRAY  = 3'd4;
   localparam logic [2:0] MAJ_MAP    = 3'd5;
   localparam logic [2:0] MAJ_TAG    = 3'd6;
   localparam logic [2:0] MAJ_SIMPLE = 3'd7;

   // Additional info boundaries
   localparam logic [4:0] AI_LEN1 = 5'd24;
   localparam logic [4:0] AI_BAD  = 5'd28;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_TRUNC  = 2'd1,
      ST_DEEP   = 2'd2,
      ST_BAD_AI = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_HEAD  = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_SKIP  = 4'b0100,
      PH_DRAIN = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [LEN_BITS-1:0] item_bytes;
      logic [2:0]          item_major;
   } rsp_word_type;

   typedef struct packed {
      logic             leaf;
      logic             push;
      logic             clear;
      logic [CNT_W-1:0] count;
   } stack_cmd_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             leaf_last;
   } stack_stat_type;

endpackage

### rtl/cis_stack.sv
module cis_stack import cis_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  stack_cmd_type  cmd,
   output stack_stat_type stat
);

   logic [CNT_W-1:0] rem_ff [MAX_DEPTH];
   logic [CNT_W-1:0] rem_in [MAX_DEPTH];
   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_in;
   logic             found;
   logic [IDX_W-1:0] hit_idx;

   // Find the highest open level whose count does not run out with this item
   always_comb begin
      found   = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         if (LVL_W'(i) < level_ff && rem_ff[i] != CNT_W'(1)) begin
            found   = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign stat.level     = level_ff;
   assign stat.leaf_last = !found;

   // Clear, push a new count, or retire one child and pop exhausted levels
   always_comb begin
      level_in = level_ff;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         rem_in[i] = rem_ff[i];
      end
      priority if (cmd.clear) begin
         level_in = '0;
      end else if (cmd.push) begin
         level_in = level_ff + LVL_W'(1);
         for (int i = 0; i < MAX_DEPTH; i++) begin
            if (LVL_W'(i) == level_ff) begin
               rem_in[i] = cmd.count;
            end
         end
      end else if (cmd.leaf) begin
         if (found) begin
            level_in = LVL_W'(hit_idx) + LVL_W'(1);
            for (int i = 0; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) == hit_idx) begin
                  rem_in[i] = rem_ff[i] - CNT_W'(1);
               end
            end
         end else begin
            level_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_DEPTH; i++) begin
         rem_ff[i] <= rem_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

### rtl/cis_walker.sv
module cis_walker import cis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  req_word_type       word,
   input  logic [LIMIT_W-1:0] limit,
   input  stack_stat_type     stk,
   output stack_cmd_type      cmd,
   output logic               res_valid,
   output rsp_word_type       res
);

   localparam int CMP_W = LVL_W + 1;

   phase_type           phase_ff, phase_in;
   logic [3:0]          len_left_ff, len_left_in;
   logic [CNT_W-1:0]    acc_ff, acc_in;
   logic [LEN_BITS-1:0] pay_left_ff, pay_left_in;
   logic [2:0]          pend_major_ff, pend_major_in;
   logic [LEN_BITS-1:0] byte_count_ff, byte_count_in;
   logic [2:0]          top_major_ff, top_major_in;

   logic [2:0]          major;
   logic [4:0]          ai;
   logic                start;
   logic [LEN_BITS-1:0] count_base;
   logic                depth_ok;
   logic [CNT_W+7:0]    acc_shift;
   logic [CNT_W-1:0]    acc_next;
   logic [3:0]          len_dec;
   logic [LEN_BITS-1:0] pay_dec;
   logic                tv_do;
   logic [2:0]          tv_major;
   logic [CNT_W-1:0]    tv_value;
   status_type          status;

   assign major      = word.data_byte[7:5];
   assign ai         = word.data_byte[4:0];
   assign start      = (phase_ff == PH_HEAD) && (stk.level == '0);
   assign count_base = start ? '0 : byte_count_ff;
   assign depth_ok   = (CMP_W'(stk.level) + CMP_W'(1)) < CMP_W'(limit);
   assign len_dec    = len_left_ff - 4'd1;
   assign pay_dec    = pay_left_ff - LEN_BITS'(1);

   // Shift in one length byte, saturating just above the largest length
   assign acc_shift = {acc_ff, word.data_byte};
   assign acc_next  = (|acc_shift[CNT_W+7:LEN_BITS]) ? CNT_W'(1) << LEN_BITS
                                                    : CNT_W'(acc_shift[LEN_BITS-1:0]);

   always_comb begin
      phase_in      = phase_ff;
      len_left_in   = len_left_ff;
      acc_in        = acc_ff;
      pay_left_in   = pay_left_ff;
      pend_major_in = pend_major_ff;
      byte_count_in = byte_count_ff;
      top_major_in  = top_major_ff;
      cmd           = '0;
      res_valid     = 1'b0;
      status        = ST_OK;
      tv_do         = 1'b0;
      tv_major      = pend_major_ff;
      tv_value      = acc_next;

      if (step) begin
         if (phase_ff == PH_DRAIN) begin
            // Drop bytes up to the end of the buffer
            if (word.last_byte) begin
               phase_in = PH_HEAD;
            end
         end else begin
            if (start) begin
               top_major_in = major;
            end
            priority if (count_base == '1) begin
               byte_count_in = '1;
               res_valid     = 1'b1;
               status        = ST_TRUNC;
            end else begin
               byte_count_in = count_base + LEN_BITS'(1);
               unique case (phase_ff)
                  PH_HEAD: begin
                     priority if (ai >= AI_BAD) begin
                        res_valid = 1'b1;
                        status    = ST_BAD_AI;
                     end else if (ai < AI_LEN1) begin
                        tv_do    = 1'b1;
                        tv_major = major;
                        tv_value = CNT_W'(ai);
                     end else if (major == MAJ_SIMPLE) begin
                        pay_left_in = LEN_BITS'(1) << ai[1:0];
                        phase_in    = PH_SKIP;
                     end else begin
                        pend_major_in = major;
                        len_left_in   = 4'd1 << ai[1:0];
                        acc_in        = '0;
                        phase_in      = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     acc_in      = acc_next;
                     len_left_in = len_dec;
                     if (len_dec == 4'd0) begin
                        phase_in = PH_HEAD;
                        tv_do    = 1'b1;
                     end
                  end
                  PH_SKIP: begin
                     pay_left_in = pay_dec;
                     if (pay_dec == '0) begin
                        phase_in  = PH_HEAD;
                        cmd.leaf  = 1'b1;
                        res_valid = stk.leaf_last;
                     end
                  end
                  default: begin
                  end
               endcase

               // Act on a finished head value
               if (tv_do) begin
                  unique case (tv_major)
                     MAJ_BYTES, MAJ_TEXT: begin
                        priority if (tv_value[LEN_BITS]) begin
                           res_valid = 1'b1;
                           status    = ST_TRUNC;
                        end else if (tv_value == '0) begin
                           cmd.leaf  = 1'b1;
                           res_valid = stk.leaf_last;
                        end else begin
                           pay_left_in = tv_value[LEN_BITS-1:0];
                           phase_in    = PH_SKIP;
                        end
                     end
                     MAJ_ARRAY, MAJ_MAP: begin
                        priority if (tv_value == '0) begin
                           cmd.leaf  = 1'b1;
                           res_valid = stk.leaf_last;
                        end else if (!depth_ok) begin
                           res_valid = 1'b1;
                           status    = ST_DEEP;
                        end else if (tv_value[LEN_BITS]) begin
                           res_valid = 1'b1;
                           status    = ST_TRUNC;
                        end else begin
                           cmd.push  = 1'b1;
                           cmd.count = (tv_major == MAJ_MAP)
                                       ? {tv_value[LEN_BITS-1:0], 1'b0} : tv_value;
                        end
                     end
                     MAJ_TAG: begin
                        if (!depth_ok) begin
                           res_valid = 1'b1;
                           status    = ST_DEEP;
                        end else begin
                           cmd.push  = 1'b1;
                           cmd.count = CNT_W'(1);
                        end
                     end
                     default: begin
                        cmd.leaf  = 1'b1;
                        res_valid = stk.leaf_last;
                     end
                  endcase
               end
            end

            // End of buffer inside an item
            if (!res_valid && word.last_byte) begin
               res_valid = 1'b1;
               status    = ST_TRUNC;
            end

            if (res_valid) begin
               if (status != ST_OK) begin
                  cmd.clear = 1'b1;
                  phase_in  = word.last_byte ? PH_HEAD : PH_DRAIN;
               end else begin
                  phase_in = PH_HEAD;
               end
            end
         end
      end
   end

   assign res.status     = status;
   assign res.item_bytes = byte_count_in;
   assign res.item_major = top_major_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEAD;
         len_left_ff   <= '0;
         acc_ff        <= '0;
         pay_left_ff   <= '0;
         pend_major_ff <= MAJ_UINT;
         byte_count_ff <= '0;
         top_major_ff  <= MAJ_UINT;
      end else begin
         phase_ff      <= phase_in;
         len_left_ff   <= len_left_in;
         acc_ff        <= acc_in;
         pay_left_ff   <= pay_left_in;
         pend_major_ff <= pend_major_in;
         byte_count_ff <= byte_count_in;
         top_major_ff  <= top_major_in;
      end
   end

endmodule

### rtl/cbor_item_skipper.sv
// Walks CBOR data items arriving one byte per word and returns one result word per
// complete top-level item, or per error (truncation or oversize, nesting too deep,
// bad additional info). A byte is taken every cycle unless the input side stalls:
// each accepted byte is held in an input register, then the head decoder and the
// combinational pop search over the 16-entry count stack update the state and, when
// an item ends, load the result register, which offers the result word.
// The input side stalls only while the result register is full and stalled. After
// an error the bytes up to the one flagged last are dropped. No clearing pass
// follows reset; the nesting limit may be rewritten whenever no item is in flight.
module cbor_item_skipper import cis_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_word,
   input  logic               csr_write_en,
   input  logic [LIMIT_W-1:0] csr_write_data
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] eff_limit;
   logic               in_valid_ff, in_valid_in;
   req_word_type       in_word_ff, in_word_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       out_word_ff, out_word_in;
   logic               step_fire;
   logic               res_valid;
   rsp_word_type       res;
   stack_cmd_type      stk_cmd;
   stack_stat_type     stk_stat;

   // Hold the nesting limit, clamped to the supported range
   assign limit_in  = csr_write_en ? csr_write_data : limit_ff;
   assign eff_limit = (limit_ff == '0) ? LIMIT_W'(1)
                    : (limit_ff > LIMIT_W'(MAX_DEPTH)) ? LIMIT_W'(MAX_DEPTH) : limit_ff;

   // Advance a byte when the result register can take what it produces
   assign step_fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !step_fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (step_fire && res_valid) begin
         out_valid_in = 1'b1;
         out_word_in  = res;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   cis_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .step      (step_fire),
      .word      (in_word_ff),
      .limit     (eff_limit),
      .stk       (stk_stat),
      .cmd       (stk_cmd),
      .res_valid (res_valid),
      .res       (res)
   );

   cis_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   // Every result, good or bad, leaves the count stack empty
   assert property (@(posedge clock) disable iff (reset)
      step_fire && res_valid |=> stk_stat.level == '0)
      else $error("stack not empty after a result");

   // The stack never climbs past its last entry
   assert property (@(posedge clock) disable iff (reset)
      stk_stat.level < LVL_W'(MAX_DEPTH))
      else $error("stack level beyond depth");

   // A byte waiting in the input register is not lost
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_fire |=> in_valid_ff && $stable(in_word_ff))
      else $error("waiting input byte dropped");

endmodule
